[src/cursor_bound_clamp_top_assert.svh]
// Assertion macros for the cursor clamp block
`ifndef CURSOR_BOUND_CLAMP_TOP_ASSERT_SVH
`define CURSOR_BOUND_CLAMP_TOP_ASSERT_SVH

// Checked on every rising edge outside reset.
`define CBC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define CBC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[src/cbc_pkg.sv]
// Shared constants, register codes and pipeline types for the cursor clamp block
`timescale 1ns / 1ps

package cbc_pkg;

    localparam int COORD_W   = 12;                 // coordinate width
    localparam int DATA_W    = 2 * COORD_W;        // stream payload width
    localparam int ADDR_W    = 5;                  // five registers, 4-byte spacing
    localparam int APB_DW    = 32;
    localparam int PROD_W    = 2 * COORD_W + 4;    // dx2*b and sums of two of them
    localparam int MAG_W     = 2 * COORD_W + 1;    // |u-v| <= 2*a*b
    localparam int QW        = COORD_W + 1;        // |q| <= 2*a
    localparam int DIV_STEPS = QW;                 // one quotient bit per stage
    localparam int NSTG      = DIV_STEPS + 5;      // total register stages
    localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};

    typedef enum logic [ADDR_W-3:0] {
        REG_LEFT   = 3'd0,
        REG_TOP    = 3'd1,
        REG_RIGHT  = 3'd2,
        REG_BOTTOM = 3'd3,
        REG_SHAPE  = 3'd4
    } t_reg_idx;

    // fields carried alongside the arithmetic
    typedef struct packed {
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [COORD_W-1:0] rx;   // rectangle clamp result
        logic [COORD_W-1:0] ry;
        logic               rh;   // rhombus path taken
    } t_pass;

    // restoring divider state
    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [QW-1:0]    q;
        logic             neg;
    } t_div;

endpackage

[src/cursor_bound_clamp_top.sv]
// Cursor confinement block: APB bound registers and an 18-stage clamp pipeline
`timescale 1ns / 1ps

// Cursor bound clamp.
// Slave stream s_* takes one item per cycle unless the pipeline is full and stalled: tdata = {pos_y, pos_x}.
// Master stream m_* returns one item per input: tdata = {clamped_y, clamped_x},
// tuser = moved (position altered by the clamp).
// APB port holds the bounds: left 0x00, top 0x04, right 0x08, bottom 0x0C,
// shape 0x10 (0 rectangle, 1 rhombus inscribed in the rectangle).
// Bounds must only change while no item is in flight.
// Throughput is one item per cycle unless the pipeline is full and stalled.
// The stages follow the rhombus path: subtract, multiplies, clamp, magnitude,
// then 13 stages of a restoring divider (one quotient bit per stage, x and y
// dividers side by side) and the output stage.
// Each stage keeps a valid bit; a stage loads whenever m_tready is high or it
// or any stage after it is empty, so bubbles close up and s_tready stays high
// while m_tready is low until all 18 stages are full. Nothing is dropped or
// repeated on a stall. Reset (synchronous, active low) empties the pipeline
// and restores the bounds to the full 0..4095 square in rectangle mode.
module cursor_bound_clamp_top
    import cbc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input items
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [DATA_W-1:0]   s_tdata,    // [11:0] pos_x, [23:12] pos_y
    // result items
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [DATA_W-1:0]   m_tdata,    // [11:0] clamped_x, [23:12] clamped_y
    output logic                m_tuser,    // [0] moved
    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    // ---------------- bound registers ----------------
    logic [COORD_W-1:0] r_left, r_top, r_right, r_bottom;
    logic               r_shape;
    logic               w_wr;
    t_reg_idx           w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_top    <= '0;
            r_right  <= COORD_MAX;
            r_bottom <= COORD_MAX;
            r_shape  <= 1'b0;
        end else if (w_wr) begin
            case (w_idx)
                REG_LEFT:   r_left   <= pwdata[COORD_W-1:0];
                REG_TOP:    r_top    <= pwdata[COORD_W-1:0];
                REG_RIGHT:  r_right  <= pwdata[COORD_W-1:0];
                REG_BOTTOM: r_bottom <= pwdata[COORD_W-1:0];
                REG_SHAPE:  r_shape  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_LEFT:   prdata = APB_DW'(r_left);
            REG_TOP:    prdata = APB_DW'(r_top);
            REG_RIGHT:  prdata = APB_DW'(r_right);
            REG_BOTTOM: prdata = APB_DW'(r_bottom);
            REG_SHAPE:  prdata = APB_DW'(r_shape);
            default:    prdata = '0;
        endcase
    end

    // Width and height of the region; only meaningful when both are positive.
    logic [COORD_W-1:0] w_a, w_b;
    assign w_a = r_right - r_left;
    assign w_b = r_bottom - r_top;

    // ---------------- flow control ----------------
    // Stage k loads when the sink is ready (m_tready) or any stage from k on is empty.
    logic [NSTG-1:0] r_vld, n_vld, w_en;

    always_comb begin
        for (int k = 0; k < NSTG; k++) begin
            w_en[k] = m_tready || (|(~r_vld & ({NSTG{1'b1}} << k)));
        end
        n_vld = (w_en & {r_vld[NSTG-2:0], s_tvalid}) | (~w_en & r_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign s_tready = w_en[0];
    assign m_tvalid = r_vld[NSTG-1];

    // ---------------- stage 0: offsets and rectangle clamp ----------------
    logic [COORD_W-1:0]        w_px, w_py, w_rx0, w_ry0;
    logic signed [COORD_W+2:0] w_dx2, w_dy2;
    t_pass                     w_pass0;

    assign w_px = s_tdata[COORD_W-1:0];
    assign w_py = s_tdata[DATA_W-1:COORD_W];

    always_comb begin
        w_dx2 = $signed({2'b0, w_px, 1'b0}) - $signed({3'b0, r_left})
              - $signed({3'b0, r_right});
        w_dy2 = $signed({2'b0, w_py, 1'b0}) - $signed({3'b0, r_top})
              - $signed({3'b0, r_bottom});
        // raise to the low bound, then lower to the high one
        w_rx0 = (w_px < r_left) ? r_left : w_px;
        w_ry0 = (w_py < r_top) ? r_top : w_py;
        w_pass0.px = w_px;
        w_pass0.py = w_py;
        w_pass0.rx = (w_rx0 > r_right) ? r_right : w_rx0;
        w_pass0.ry = (w_ry0 > r_bottom) ? r_bottom : w_ry0;
        w_pass0.rh = r_shape && (r_right > r_left) && (r_bottom > r_top);
    end

    t_pass                     r_pass [NSTG-1];
    logic signed [COORD_W+2:0] r_dx2, r_dy2;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_pass[0] <= w_pass0;
            r_dx2     <= w_dx2;
            r_dy2     <= w_dy2;
        end
    end

    for (genvar k = 1; k < NSTG - 1; k++) begin : g_pass
        always_ff @(posedge i_clk) begin
            if (w_en[k]) begin
                r_pass[k] <= r_pass[k-1];
            end
        end
    end

    // ---------------- stage 1: products ----------------
    logic signed [PROD_W-1:0] r_p1, r_p2;
    logic [2*COORD_W-1:0]     r_ab;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_p1 <= r_dx2 * $signed({1'b0, w_b});
            r_p2 <= r_dy2 * $signed({1'b0, w_a});
            r_ab <= w_a * w_b;
        end
    end

    // ---------------- stage 2: u, v clamped to +-a*b ----------------
    logic signed [PROD_W-1:0] w_u, w_v, w_lim, w_uc, w_vc;
    logic signed [MAG_W-1:0]  r_u, r_v;

    always_comb begin
        w_u   = r_p1 + r_p2;
        w_v   = r_p2 - r_p1;
        w_lim = $signed({4'b0, r_ab});
        w_uc  = (w_u > w_lim) ? w_lim : ((w_u < -w_lim) ? -w_lim : w_u);
        w_vc  = (w_v > w_lim) ? w_lim : ((w_v < -w_lim) ? -w_lim : w_v);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_u <= w_uc[MAG_W-1:0];
            r_v <= w_vc[MAG_W-1:0];
        end
    end

    // ---------------- stage 3: sign and magnitude of dividends ----------------
    logic signed [MAG_W:0] w_dif, w_sum, w_dif_abs, w_sum_abs;
    t_div                  r_divx [DIV_STEPS+1];
    t_div                  r_divy [DIV_STEPS+1];

    always_comb begin
        w_dif     = (MAG_W+1)'(r_u) - (MAG_W+1)'(r_v);
        w_sum     = (MAG_W+1)'(r_u) + (MAG_W+1)'(r_v);
        w_dif_abs = w_dif[MAG_W] ? -w_dif : w_dif;
        w_sum_abs = w_sum[MAG_W] ? -w_sum : w_sum;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_divx[0] <= '{rem: w_dif_abs[MAG_W-1:0], q: '0, neg: w_dif[MAG_W]};
            r_divy[0] <= '{rem: w_sum_abs[MAG_W-1:0], q: '0, neg: w_sum[MAG_W]};
        end
    end

    // ---------------- stages 4..16: restoring divide, MSB first ----------------
    // x: (u-v)/b, y: (u+v)/a. The quotient fits QW bits, so the first trial
    // subtracts the divisor shifted up by QW-1.
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        localparam int BIT = QW - 1 - k;
        logic [MAG_W:0] w_trx, w_try;
        t_div           w_nx, w_ny;

        always_comb begin
            w_trx = {1'b0, r_divx[k].rem}
                  - ({{(MAG_W+1-COORD_W){1'b0}}, w_b} << BIT);
            w_try = {1'b0, r_divy[k].rem}
                  - ({{(MAG_W+1-COORD_W){1'b0}}, w_a} << BIT);
            w_nx = r_divx[k];
            w_ny = r_divy[k];
            if (!w_trx[MAG_W]) begin
                w_nx.rem    = w_trx[MAG_W-1:0];
                w_nx.q[BIT] = 1'b1;
            end
            if (!w_try[MAG_W]) begin
                w_ny.rem    = w_try[MAG_W-1:0];
                w_ny.q[BIT] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[4+k]) begin
                r_divx[k+1] <= w_nx;
                r_divy[k+1] <= w_ny;
            end
        end
    end

    // ---------------- stage 17: halve, recentre, select, output ----------------
    // q/2 toward zero is a shift of the magnitude; the recentred sum is never
    // negative, so the last halving is a shift as well.
    logic [COORD_W-1:0] w_hx, w_hy;
    logic [COORD_W+2:0] w_sx, w_sy;
    logic [COORD_W:0]   w_nx, w_ny;
    t_pass              w_pf;

    always_comb begin
        w_pf = r_pass[NSTG-2];
        w_hx = r_divx[DIV_STEPS].q[QW-1:1];
        w_hy = r_divy[DIV_STEPS].q[QW-1:1];
        w_sx = {3'b0, r_left} + {3'b0, r_right};
        w_sy = {3'b0, r_top} + {3'b0, r_bottom};
        w_sx = r_divx[DIV_STEPS].neg ? (w_sx - {3'b0, w_hx}) : (w_sx + {3'b0, w_hx});
        w_sy = r_divy[DIV_STEPS].neg ? (w_sy - {3'b0, w_hy}) : (w_sy + {3'b0, w_hy});
        w_nx = w_pf.rh ? w_sx[COORD_W+1:1] : {1'b0, w_pf.rx};
        w_ny = w_pf.rh ? w_sy[COORD_W+1:1] : {1'b0, w_pf.ry};
    end

    logic [COORD_W-1:0] r_out_x, r_out_y;
    logic               r_out_mv;

    always_ff @(posedge i_clk) begin
        if (w_en[NSTG-1]) begin
            r_out_x  <= w_nx[COORD_W-1:0];
            r_out_y  <= w_ny[COORD_W-1:0];
            r_out_mv <= (w_nx != {1'b0, w_pf.px}) || (w_ny != {1'b0, w_pf.py});
        end
    end

    assign m_tdata = {r_out_y, r_out_x};
    assign m_tuser = r_out_mv;

endmodule

[src/cbc_checker.sv]
// Port-level checker for the cursor clamp block, bound to the top level
`timescale 1ns / 1ps

`include "cursor_bound_clamp_top_assert.svh"

module cbc_checker
    import cbc_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,   // [11:0] clamped_x, [23:12] clamped_y
    input logic              m_tuser    // [0] moved
);

    // reset empties the pipeline
    `CBC_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !m_tvalid, "output valid after reset")

    // an empty pipeline takes input straight away
    `CBC_ASSERT_ALWAYS(a_rst_ready, !i_rst_n |=> s_tready, "input blocked after reset")

    // input only backs up when the output is full and stalled
    `CBC_ASSERT(a_ready_free, (!m_tvalid || m_tready) |-> s_tready,
                "input blocked while output side is free")

    // a stalled result holds
    `CBC_ASSERT(a_out_hold,
                m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser),
                "stalled result changed")

endmodule

bind cursor_bound_clamp_top cbc_checker u_cbc_checker (.*);

[tb/sv/tb.sv]
// Self-checking testbench for the cursor bound clamp: stream traffic, APB bounds, predictor
`timescale 1ns / 1ps

// What is exercised:
// - directed table first: reset bounds, tight and inverted rectangles, full-square rhombus,
//   1x1 rhombus, flat and inverted rhombus (both fall back to the rectangle clamp), odd sizes
// - then random phases, each with fresh bounds (extremes mixed in) and idling on or off per side
// - every bound write goes out with junk in the upper pwdata bits and is read back;
//   writes to unused register slots must leave the bounds alone
// Results are compared field by field, in order, with a local model of the clamp or a hand-worked result.
module tb;
    import cbc_pkg::*;

    localparam int LATENCY        = 18;          // accept to m_tvalid, unstalled
    localparam int DRAIN_PAD      = LATENCY + 4;
    localparam int WATCHDOG_LIMIT = 2000;        // cycles with no handshake of any kind
    localparam int N_PHASES       = 20;
    localparam int PHASE_ITEMS    = 50;
    localparam int DIR_N          = 23;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               moved;
    } t_pos_res;

    // one directed item: bounds to apply, position, and optionally a hand-worked result
    typedef struct packed {
        logic               shape;
        logic [COORD_W-1:0] l;
        logic [COORD_W-1:0] t;
        logic [COORD_W-1:0] r;
        logic [COORD_W-1:0] b;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic               typed;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
        logic               em;
    } t_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata;    // [11:0] pos_x, [23:12] pos_y
    logic                m_tvalid;
    logic                m_tready;
    logic [DATA_W-1:0]   m_tdata;    // [11:0] clamped_x, [23:12] clamped_y
    logic                m_tuser;    // [0] moved
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    cursor_bound_clamp_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // local copy of the bound registers, kept in step with every APB write
    logic [COORD_W-1:0] cfg_left;
    logic [COORD_W-1:0] cfg_top;
    logic [COORD_W-1:0] cfg_right;
    logic [COORD_W-1:0] cfg_bottom;
    logic               cfg_shape;

    t_pos_res pending_pos [$];   // results owed by the block, oldest first

    bit tx_idle;                 // per-phase: sender inserts random gaps
    bit rx_idle;                 // per-phase: receiver stalls at random
    int n_fail;
    int n_sent;
    int n_results;
    int n_rhomb;
    int n_settings;
    int idle_cycles;

    t_row dir_rows [DIR_N] = '{
        // reset bounds: full square, nothing moves
        '{1'b0, 12'd0, 12'd0, 12'd4095, 12'd4095, 12'd0, 12'd0,
          1'b1, 12'd0, 12'd0, 1'b0},
        '{1'b0, 12'd0, 12'd0, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
          1'b1, 12'd4095, 12'd4095, 1'b0},
        '{1'b0, 12'd0, 12'd0, 12'd4095, 12'd4095, 12'd4095, 12'd0,
          1'b1, 12'd4095, 12'd0, 1'b0},
        '{1'b0, 12'd0, 12'd0, 12'd4095, 12'd4095, 12'd0, 12'd4095,
          1'b1, 12'd0, 12'd4095, 1'b0},
        // ordinary rectangle, both corners outside and one point inside
        '{1'b0, 12'd100, 12'd200, 12'd300, 12'd400, 12'd0, 12'd0,
          1'b1, 12'd100, 12'd200, 1'b1},
        '{1'b0, 12'd100, 12'd200, 12'd300, 12'd400, 12'd4095, 12'd4095,
          1'b1, 12'd300, 12'd400, 1'b1},
        '{1'b0, 12'd100, 12'd200, 12'd300, 12'd400, 12'd150, 12'd250,
          1'b1, 12'd150, 12'd250, 1'b0},
        // inverted rectangle: always lands on right / bottom
        '{1'b0, 12'd500, 12'd600, 12'd100, 12'd50, 12'd0, 12'd0,
          1'b1, 12'd100, 12'd50, 1'b1},
        '{1'b0, 12'd500, 12'd600, 12'd100, 12'd50, 12'd300, 12'd300,
          1'b1, 12'd100, 12'd50, 1'b1},
        '{1'b0, 12'd500, 12'd600, 12'd100, 12'd50, 12'd100, 12'd50,
          1'b1, 12'd100, 12'd50, 1'b0},
        // rhombus in the full square
        '{1'b1, 12'd0, 12'd0, 12'd4095, 12'd4095, 12'd2047, 12'd2047, 1'b0, 12'd0, 12'd0, 1'b0},
        '{1'b1, 12'd0, 12'd0, 12'd4095, 12'd4095, 12'd0, 12'd0, 1'b0, 12'd0, 12'd0, 1'b0},
        '{1'b1, 12'd0, 12'd0, 12'd4095, 12'd4095, 12'd4095, 12'd0, 1'b0, 12'd0, 12'd0, 1'b0},
        '{1'b1, 12'd0, 12'd0, 12'd4095, 12'd4095, 12'd0, 12'd4095, 1'b0, 12'd0, 12'd0, 1'b0},
        '{1'b1, 12'd0, 12'd0, 12'd4095, 12'd4095, 12'd2048, 12'd0, 1'b0, 12'd0, 12'd0, 1'b0},
        '{1'b1, 12'd0, 12'd0, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0, 12'd0, 12'd0, 1'b0},
        // smallest rhombus, a = b = 1
        '{1'b1, 12'd1000, 12'd1000, 12'd1001, 12'd1001, 12'd0, 12'd0,
          1'b0, 12'd0, 12'd0, 1'b0},
        '{1'b1, 12'd1000, 12'd1000, 12'd1001, 12'd1001, 12'd4095, 12'd4095,
          1'b0, 12'd0, 12'd0, 1'b0},
        // zero-width rhombus falls back to the rectangle clamp
        '{1'b1, 12'd700, 12'd100, 12'd700, 12'd900, 12'd0, 12'd0,
          1'b1, 12'd700, 12'd100, 1'b1},
        '{1'b1, 12'd700, 12'd100, 12'd700, 12'd900, 12'd4095, 12'd500,
          1'b1, 12'd700, 12'd500, 1'b1},
        // negative width rhombus: rectangle clamp, x ends at right
        '{1'b1, 12'd900, 12'd0, 12'd100, 12'd4095, 12'd0, 12'd0,
          1'b1, 12'd100, 12'd0, 1'b1},
        // even width and odd height, so the halving truncates in y
        '{1'b1, 12'd0, 12'd0, 12'd4094, 12'd4095, 12'd4095, 12'd2047,
          1'b0, 12'd0, 12'd0, 1'b0},
        '{1'b1, 12'd0, 12'd0, 12'd4094, 12'd4095, 12'd1, 12'd4094,
          1'b0, 12'd0, 12'd0, 1'b0}
    };

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Where the block should put a cursor under the current bounds.
    function automatic t_pos_res confine_pos(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
        longint x1, y1, x2, y2, a, b, sx, sy;
        longint dx2, dy2, ab, u, v, nx, ny;
        t_pos_res res;
        sx = px;
        sy = py;
        x1 = cfg_left;
        y1 = cfg_top;
        x2 = cfg_right;
        y2 = cfg_bottom;
        a  = x2 - x1;
        b  = y2 - y1;
        if (cfg_shape && a > 0 && b > 0) begin
            dx2 = 2 * sx - x1 - x2;
            dy2 = 2 * sy - y1 - y2;
            ab  = a * b;
            u   = dx2 * b + dy2 * a;
            v   = dy2 * a - dx2 * b;
            if (u > ab) u = ab;
            if (u < -ab) u = -ab;
            if (v > ab) v = ab;
            if (v < -ab) v = -ab;
            // longint division truncates toward zero, as required
            nx = (x1 + x2 + ((u - v) / b) / 2) / 2;
            ny = (y1 + y2 + ((u + v) / a) / 2) / 2;
        end else begin
            // raise to the low edge first, then lower to the high edge
            nx = sx;
            if (nx < x1) nx = x1;
            if (nx > x2) nx = x2;
            ny = sy;
            if (ny < y1) ny = y1;
            if (ny > y2) ny = y2;
        end
        res.x     = nx[COORD_W-1:0];
        res.y     = ny[COORD_W-1:0];
        res.moved = (nx != sx) || (ny != sy);
        return res;
    endfunction

    function automatic logic [COORD_W-1:0] near_coord(logic [COORD_W-1:0] e0,
                                                      logic [COORD_W-1:0] e1);
        int lo, hi;
        lo = ((e0 < e1) ? e0 : e1) - 64;
        hi = ((e0 < e1) ? e1 : e0) + 64;
        if (lo < 0) lo = 0;
        if (hi > COORD_MAX) hi = COORD_MAX;
        return $urandom_range(hi, lo);
    endfunction

    // One APB transfer: setup, access until pready, then back to idle.
    task automatic apb_access(input bit wr, input logic [ADDR_W-3:0] idx,
                              input logic [APB_DW-1:0] data, output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Register write with junk above the field, mirror update, read-back of known slots.
    task automatic write_reg(input logic [ADDR_W-3:0] idx, input logic [COORD_W-1:0] val);
        logic [APB_DW-1:0] w, rd, want;
        bit known;
        w     = $urandom();
        known = 1'b1;
        want  = '0;
        if (idx == REG_SHAPE) w[0] = val[0];
        else w[COORD_W-1:0] = val;
        apb_access(1'b1, idx, w, rd);
        case (t_reg_idx'(idx))
            REG_LEFT: begin
                cfg_left = w[COORD_W-1:0];
                want     = cfg_left;
            end
            REG_TOP: begin
                cfg_top = w[COORD_W-1:0];
                want    = cfg_top;
            end
            REG_RIGHT: begin
                cfg_right = w[COORD_W-1:0];
                want      = cfg_right;
            end
            REG_BOTTOM: begin
                cfg_bottom = w[COORD_W-1:0];
                want       = cfg_bottom;
            end
            REG_SHAPE: begin
                cfg_shape = w[0];
                want      = cfg_shape;
            end
            default: known = 1'b0;   // unused slot: must be ignored
        endcase
        if (known) begin
            apb_access(1'b0, idx, '0, rd);
            if (rd !== want) begin
                $error("register %0d read-back: expected %0h, actual %0h", idx, want, rd);
                n_fail++;
            end
        end
    endtask

    // Stop sending and let the pipeline empty out completely.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_pos.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    // Bounds change only with nothing in flight; only differing registers are written.
    task automatic set_bounds(input logic shape, input logic [COORD_W-1:0] l,
                              input logic [COORD_W-1:0] t, input logic [COORD_W-1:0] r,
                              input logic [COORD_W-1:0] b);
        if (shape != cfg_shape || l != cfg_left || t != cfg_top ||
            r != cfg_right || b != cfg_bottom) begin
            wait_idle();
            if (l != cfg_left) write_reg(REG_LEFT, l);
            if (t != cfg_top) write_reg(REG_TOP, t);
            if (r != cfg_right) write_reg(REG_RIGHT, r);
            if (b != cfg_bottom) write_reg(REG_BOTTOM, b);
            if (shape != cfg_shape) write_reg(REG_SHAPE, {{(COORD_W-1){1'b0}}, shape});
            n_settings++;
        end
    endtask

    // Offer one position, hold it until taken, then log what it must produce.
    task automatic send_pos(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                            input t_pos_res want);
        int gap;
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {py, px};
        do @(posedge i_clk); while (!s_tready);
        pending_pos.push_back(want);
        n_sent++;
        if (cfg_shape && cfg_right > cfg_left && cfg_bottom > cfg_top) n_rhomb++;
    endtask

    // Result side: random stalls, then field-by-field check against the oldest expectation.
    initial begin : result_side
        int gap;
        t_pos_res got, want;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = rx_idle ? $urandom_range(0, 15) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            got.x     = m_tdata[COORD_W-1:0];
            got.y     = m_tdata[DATA_W-1:COORD_W];
            got.moved = m_tuser;
            n_results++;
            if (pending_pos.size() == 0) begin
                $error("result with nothing expected: x %0d y %0d moved %0b",
                       got.x, got.y, got.moved);
                n_fail++;
            end else begin
                want = pending_pos.pop_front();
                if (got.x !== want.x) begin
                    $error("clamped_x: expected %0d, actual %0d", want.x, got.x);
                    n_fail++;
                end
                if (got.y !== want.y) begin
                    $error("clamped_y: expected %0d, actual %0d", want.y, got.y);
                    n_fail++;
                end
                if (got.moved !== want.moved) begin
                    $error("moved: expected %0b, actual %0b", want.moved, got.moved);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog: any handshake on either stream or the APB port counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("cursor_bound_clamp_top regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        int ph, k, kind, sel;
        logic [COORD_W-1:0] l, t, r, bo, px, py, c0, c1;
        logic sh;
        t_row row;
        t_pos_res want;

        i_rst_n     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        m_tready    <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        idle_cycles = 0;
        n_fail      = 0;
        n_sent      = 0;
        n_results   = 0;
        n_rhomb     = 0;
        n_settings  = 1;
        tx_idle     = 1'b1;
        rx_idle     = 1'b1;
        // bounds after reset: full square, rectangle mode
        cfg_left    = '0;
        cfg_top     = '0;
        cfg_right   = COORD_MAX;
        cfg_bottom  = COORD_MAX;
        cfg_shape   = 1'b0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int i = 0; i < DIR_N; i++) begin
            row = dir_rows[i];
            set_bounds(row.shape, row.l, row.t, row.r, row.b);
            if (row.typed) begin
                want.x     = row.ex;
                want.y     = row.ey;
                want.moved = row.em;
            end else begin
                want = confine_pos(row.px, row.py);
            end
            send_pos(row.px, row.py, want);
        end

        // random phases, each under its own bounds
        for (ph = 0; ph < N_PHASES; ph++) begin
            tx_idle = (ph % 5 != 1);
            rx_idle = (ph % 3 != 1);       // phase 1 runs flat out on both sides
            kind = (ph == 0) ? 0 : $urandom_range(0, 6);
            sh   = ($urandom_range(0, 3) != 0);
            case (kind)
                0: begin
                    l = '0; t = '0; r = COORD_MAX; bo = COORD_MAX;
                end
                2: begin   // small region
                    l  = $urandom_range(0, 4000);
                    r  = l + $urandom_range(1, 60);
                    t  = $urandom_range(0, 4000);
                    bo = t + $urandom_range(1, 60);
                end
                3: begin   // unordered, often inverted
                    l = $urandom(); t = $urandom(); r = $urandom(); bo = $urandom();
                end
                5: begin   // one-pixel rhombus
                    l  = $urandom_range(0, 4094);
                    r  = l + 1;
                    t  = $urandom_range(0, 4094);
                    bo = t + 1;
                end
                6: begin   // full width, random height
                    l  = '0;
                    r  = COORD_MAX;
                    t  = $urandom_range(0, 2047);
                    bo = $urandom_range(2048, 4095);
                end
                default: begin   // ordered random edges, flattened in kind 4
                    c0 = $urandom(); c1 = $urandom();
                    l  = (c0 < c1) ? c0 : c1;
                    r  = (c0 < c1) ? c1 : c0;
                    c0 = $urandom(); c1 = $urandom();
                    t  = (c0 < c1) ? c0 : c1;
                    bo = (c0 < c1) ? c1 : c0;
                    if (kind == 4) begin
                        if ($urandom_range(0, 1)) r = l;
                        else bo = t;
                    end
                end
            endcase
            wait_idle();
            // an unused register slot must not disturb the bounds
            write_reg(3'(int'(REG_SHAPE) + $urandom_range(1, 3)), 12'($urandom()));
            set_bounds(sh, l, t, r, bo);

            for (k = 0; k < PHASE_ITEMS; k++) begin
                // once, hold off mid-phase until the pipeline has fully emptied
                if (ph == 3 && k == PHASE_ITEMS / 2) wait_idle();
                sel = $urandom_range(0, 9);
                if (sel < 5) begin
                    px = near_coord(cfg_left, cfg_right);
                    py = near_coord(cfg_top, cfg_bottom);
                end else if (sel < 9) begin
                    px = $urandom();
                    py = $urandom();
                end else begin
                    px = $urandom_range(0, 1) ? COORD_MAX : '0;
                    py = $urandom_range(0, 1) ? COORD_MAX : '0;
                end
                send_pos(px, py, confine_pos(px, py));
            end
        end

        wait_idle();
        $display("covered %0d positions over %0d bound settings, %0d on the rhombus path",
                 n_sent, n_settings, n_rhomb);
        $display("%0d results checked, %0d mismatches", n_results, n_fail);
        if (n_fail == 0)
            $display("cursor_bound_clamp_top regression: pass");
        else
            $display("cursor_bound_clamp_top regression: fail");
        $finish;
    end

endmodule
